[hw/rtl/temp_reply_frame_parser_macros.svh]
// Assertion helpers for the reply frame parser.
`ifndef TEMP_REPLY_FRAME_PARSER_MACROS_SVH
`define TEMP_REPLY_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TRFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/trfp_pkg.sv]
`default_nettype none

package trfp_pkg;

    localparam logic [7:0] ASCII_CR = 8'h0D;
    localparam logic [7:0] ASCII_LF = 8'h0A;
    localparam logic [7:0] ASCII_O  = 8'h4F;
    localparam logic [7:0] ASCII_K  = 8'h4B;

    localparam int FIELD_SPAN   = 5;
    localparam int FIELD_DIGITS = 4;

    localparam logic [5:0] OFFSET_MAX = 6'd63;

    typedef enum logic [1:0] {
        REQ_NONE      = 2'd0,
        REQ_READ_TEMP = 2'd1,
        REQ_SET_ONE   = 2'd2,
        REQ_SET_ALL   = 2'd3
    } t_request;

    typedef enum logic {
        CMD_RX_BYTE   = 1'b0,
        CMD_READ_TEMP = 1'b1
    } t_cmd;

    typedef struct packed {
        logic       bad;
        logic [3:0] nib;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.bad = 1'b0;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nib = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.nib = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.nib = 4'(c - 8'h57);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

    // Upper-case hex character of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
        end else begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/temp_reply_frame_parser.sv]
// Each byte or read is handled in a single pass: input register, then result register.
// Throughput: one input transaction per cycle unless i_ready stalls the result register.
// Frame parsing state updates in the pass stage; the result register stalls only on i_ready.
// Reset: i_rst_n synchronous active low; clears frame state, last_request and stored temps.
// Staged field values have no reset and are copied only once fully written in a frame.
`default_nettype none

module temp_reply_frame_parser #(
    parameter int CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic [3:0]  i_channel,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_frame_end,
    output logic             o_checksum_ok,
    output logic             o_reply_ok,
    output logic             o_temps_updated,
    output logic [15:0]      o_temperature,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_wdata
);

    localparam int         IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [5:0] SPAN_ALL = 6'(trfp_pkg::FIELD_SPAN * CHANNELS);
    localparam logic [2:0] POS_LAST = 3'(trfp_pkg::FIELD_SPAN - 1);
    localparam logic [2:0] DIG_LAST = 3'(trfp_pkg::FIELD_DIGITS - 1);
    localparam logic [3:0] CH_MAX   = 4'(CHANNELS);

    // input register
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [7:0]  r_in_byte;
    logic [3:0]  r_in_ch;

    // config
    trfp_pkg::t_request r_last_req;

    // frame state
    logic [7:0]  r_sum,       n_sum;
    logic [7:0]  r_hist [3];
    logic [7:0]  n_hist [3];
    logic [1:0]  r_hist_cnt,  n_hist_cnt;
    logic        r_first,     n_first;
    logic        r_ok_found,  n_ok_found;
    logic [5:0]  r_offset,    n_offset;
    logic [2:0]  r_pos,       n_pos;
    logic [IDX_W-1:0] r_idx,  n_idx;
    logic [15:0] r_acc,       n_acc;
    logic        r_field_err, n_field_err;
    logic [7:0]  r_prev,      n_prev;
    logic        r_prev_v,    n_prev_v;

    logic [15:0] r_staged  [CHANNELS];
    logic [15:0] r_current [CHANNELS];

    // result register
    logic        r_out_valid;
    logic        r_out_fe, r_out_cks, r_out_rep, r_out_upd;
    logic [15:0] r_out_temp;

    logic        w_adv;
    logic        w_take;
    logic        w_is_read;
    logic        w_frame_end;
    logic        w_cks, w_rep, w_upd;
    logic        w_tail_ok;
    logic [7:0]  w_last_hist;
    logic [15:0] w_rd_temp;
    logic [3:0]  w_ch_m1;
    logic        w_stg_we;
    logic [IDX_W-1:0] w_stg_idx;
    logic [15:0] w_stg_data;
    logic [7:0]  w_b;
    logic [5:0]  w_o_new;
    trfp_pkg::t_hex w_hex;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || w_adv;
    assign w_take  = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_cmd  <= i_cmd;
            r_in_byte <= i_rx_byte;
            r_in_ch   <= i_channel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_req <= trfp_pkg::REQ_NONE;
        end else if (i_cfg_we) begin
            r_last_req <= trfp_pkg::t_request'(i_cfg_wdata);
        end
    end

    assign w_is_read = (trfp_pkg::t_cmd'(r_in_cmd) == trfp_pkg::CMD_READ_TEMP);
    assign w_b       = r_in_byte;

    always_comb begin
        case (r_hist_cnt)
            2'd1:    w_last_hist = r_hist[0];
            2'd2:    w_last_hist = r_hist[1];
            2'd3:    w_last_hist = r_hist[2];
            default: w_last_hist = 8'd0;
        endcase
    end

    assign w_frame_end = !w_is_read && (w_b == trfp_pkg::ASCII_LF) && (r_hist_cnt != 2'd0)
                         && (w_last_hist == trfp_pkg::ASCII_CR);

    assign w_cks = (r_hist_cnt == 2'd3)
                   && (r_hist[0] == trfp_pkg::hex_char(r_sum[7:4]))
                   && (r_hist[1] == trfp_pkg::hex_char(r_sum[3:0]));

    // "OK" still held in the history, excluding the CR
    assign w_tail_ok =
        (r_hist_cnt >= 2'd2 && r_prev_v && r_prev == trfp_pkg::ASCII_O
            && r_hist[0] == trfp_pkg::ASCII_K)
        || (r_hist_cnt == 2'd3 && r_hist[0] == trfp_pkg::ASCII_O
            && r_hist[1] == trfp_pkg::ASCII_K);

    assign w_rep = r_ok_found || w_tail_ok;
    assign w_upd = r_ok_found && (r_last_req == trfp_pkg::REQ_READ_TEMP) && !r_field_err
                   && (r_offset >= SPAN_ALL);

    assign w_ch_m1 = r_in_ch - 4'd1;
    always_comb begin
        w_rd_temp = 16'd0;
        if (r_in_ch >= 4'd1 && r_in_ch <= CH_MAX) begin
            w_rd_temp = r_current[w_ch_m1[IDX_W-1:0]];
        end
    end

    assign w_o_new = (r_offset < trfp_pkg::OFFSET_MAX) ? r_offset + 6'd1 : r_offset;
    assign w_hex   = trfp_pkg::hex_value(r_hist[0]);

    always_comb begin
        n_sum       = r_sum;
        n_hist      = r_hist;
        n_hist_cnt  = r_hist_cnt;
        n_first     = r_first;
        n_ok_found  = r_ok_found;
        n_offset    = r_offset;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_field_err = r_field_err;
        n_prev      = r_prev;
        n_prev_v    = r_prev_v;
        w_stg_we    = 1'b0;
        w_stg_idx   = r_idx;
        w_stg_data  = 16'd0;
        if (w_take && !w_is_read) begin
            if (w_frame_end) begin
                n_sum       = 8'd0;
                n_hist[0]   = 8'd0;
                n_hist[1]   = 8'd0;
                n_hist[2]   = 8'd0;
                n_hist_cnt  = 2'd0;
                n_first     = 1'b1;
                n_ok_found  = 1'b0;
                n_offset    = 6'd0;
                n_acc       = 16'd0;
                n_field_err = 1'b0;
                n_prev      = 8'd0;
                n_prev_v    = 1'b0;
            end else if (r_hist_cnt == 2'd3) begin
                // oldest byte leaves the history and is checked
                if (r_first) begin
                    n_first = 1'b0;
                end else begin
                    n_sum = r_sum + r_hist[0];
                end
                if (!r_ok_found) begin
                    if (r_prev_v && r_prev == trfp_pkg::ASCII_O
                            && r_hist[0] == trfp_pkg::ASCII_K) begin
                        n_ok_found = 1'b1;
                        n_offset   = 6'd0;
                    end
                end else begin
                    n_offset = w_o_new;
                    if (w_o_new == 6'd2) begin
                        n_pos = 3'd0;
                        n_idx = '0;
                    end else if (r_pos == POS_LAST) begin
                        n_pos = 3'd0;
                        n_idx = r_idx + 1'b1;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                    if (w_o_new >= 6'd2 && w_o_new <= SPAN_ALL && n_pos <= DIG_LAST) begin
                        if (w_hex.bad) begin
                            n_field_err = 1'b1;
                        end
                        n_acc = {r_acc[11:0], w_hex.nib};
                        if (n_pos == DIG_LAST) begin
                            w_stg_we   = 1'b1;
                            w_stg_idx  = n_idx;
                            w_stg_data = n_acc;
                            n_acc      = 16'd0;
                        end
                    end
                end
                n_prev    = r_hist[0];
                n_prev_v  = 1'b1;
                n_hist[0] = r_hist[1];
                n_hist[1] = r_hist[2];
                n_hist[2] = w_b;
            end else begin
                n_hist[r_hist_cnt] = w_b;
                n_hist_cnt         = r_hist_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= 8'd0;
            r_hist[0]   <= 8'd0;
            r_hist[1]   <= 8'd0;
            r_hist[2]   <= 8'd0;
            r_hist_cnt  <= 2'd0;
            r_first     <= 1'b1;
            r_ok_found  <= 1'b0;
            r_offset    <= 6'd0;
            r_acc       <= 16'd0;
            r_field_err <= 1'b0;
            r_prev      <= 8'd0;
            r_prev_v    <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_hist      <= n_hist;
            r_hist_cnt  <= n_hist_cnt;
            r_first     <= n_first;
            r_ok_found  <= n_ok_found;
            r_offset    <= n_offset;
            r_acc       <= n_acc;
            r_field_err <= n_field_err;
            r_prev      <= n_prev;
            r_prev_v    <= n_prev_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_idx <= n_idx;
        if (w_stg_we) begin
            r_staged[w_stg_idx] <= w_stg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_current[i] <= 16'd0;
            end
        end else if (w_take && w_frame_end && w_upd) begin
            r_current <= r_staged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_take && (w_is_read || w_frame_end);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && (w_is_read || w_frame_end)) begin
            r_out_fe   <= w_frame_end;
            r_out_cks  <= w_frame_end && w_cks;
            r_out_rep  <= w_frame_end && w_rep;
            r_out_upd  <= w_frame_end && w_upd;
            r_out_temp <= w_is_read ? w_rd_temp : 16'd0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_frame_end     = r_out_fe;
    assign o_checksum_ok   = r_out_cks;
    assign o_reply_ok      = r_out_rep;
    assign o_temps_updated = r_out_upd;
    assign o_temperature   = r_out_temp;

`include "temp_reply_frame_parser_macros.svh"

    `TRFP_ASSERT_NOW(a_read_flags_clear, i_clk, i_rst_n, o_valid && !o_frame_end,
        !o_checksum_ok && !o_reply_ok && !o_temps_updated, "read result carries frame flags")
    `TRFP_ASSERT_NOW(a_upd_needs_ok, i_clk, i_rst_n, o_valid && o_temps_updated,
        o_frame_end && o_reply_ok, "update without OK frame end")
    `TRFP_ASSERT_NOW(a_frame_temp_zero, i_clk, i_rst_n, o_valid && o_frame_end,
        o_temperature == 16'd0, "frame end result has nonzero temperature")
    `TRFP_ASSERT_NEXT(a_frame_clears, i_clk, i_rst_n, w_take && w_frame_end,
        r_hist_cnt == 2'd0 && r_first && !r_ok_found && o_valid && o_frame_end,
        "frame state not cleared after frame end")

endmodule

`default_nettype wire
